// ===== hw/rtl/iar_pkg.sv =====
package iar_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_SHIFT_UP   = 2'd2,
        CMD_SHIFT_DOWN = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [IDX_W-1:0]   idx;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/iar_cell.sv =====
module iar_cell
    import iar_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int POS      = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_cell_ctl           i_ctl,
    input  logic [DATA_W-1:0]   i_left,
    input  logic [DATA_W-1:0]   i_right,
    input  logic [DATA_W-1:0]   i_value,
    output logic [DATA_W-1:0]   o_q,
    output logic [DATA_W-1:0]   o_tap
);

    localparam int CLW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW  = (CLW > IDX_W) ? CLW : IDX_W;
    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;
    logic [PW-1:0]     w_idx;
    logic              w_hit;
    logic              w_above;

    assign w_idx   = PW'(i_ctl.idx);
    assign w_hit   = (w_idx == MY_POS);
    assign w_above = (MY_POS > w_idx);

    always_comb begin
        n_q = r_q;
        case (i_ctl.cmd)
            CMD_HOLD: begin
                n_q = r_q;
            end
            CMD_WRITE: begin
                if (w_hit) begin
                    n_q = i_value;
                end
            end
            CMD_SHIFT_UP: begin
                if (w_hit) begin
                    n_q = i_value;
                end else if (w_above) begin
                    n_q = i_left;
                end
            end
            CMD_SHIFT_DOWN: begin
                if (w_hit || w_above) begin
                    n_q = i_right;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q   = r_q;
    assign o_tap = w_hit ? r_q : '0;

endmodule

// ===== hw/rtl/iar_ctrl.sv =====
module iar_ctrl
    import iar_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int LW       = 7
) (
    input  t_op                 i_op,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [LW-1:0]       i_len,
    output t_cell_ctl           o_ctl,
    output logic [LW-1:0]       o_len_nxt,
    output t_status             o_status,
    output logic                o_rd_ok
);

    localparam int CW = (LW > IDX_W + 1) ? LW : IDX_W + 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0] w_idx;
    logic [CW-1:0] w_idx1;
    logic [CW-1:0] w_len;
    logic          w_inside;

    assign w_idx    = CW'(i_idx);
    assign w_idx1   = w_idx + CW'(1);
    assign w_len    = CW'(i_len);
    assign w_inside = (w_idx < w_len);

    always_comb begin
        o_ctl.cmd = CMD_HOLD;
        o_ctl.idx = i_idx;
        o_len_nxt = i_len;
        o_status  = ST_OK;
        o_rd_ok   = 1'b0;
        case (i_op)
            OP_READ: begin
                if (w_inside) begin
                    o_rd_ok = 1'b1;
                end else begin
                    o_status = ST_RANGE;
                end
            end
            OP_REMOVE: begin
                if (w_inside) begin
                    o_ctl.cmd = CMD_SHIFT_DOWN;
                    o_len_nxt = LW'(w_len - CW'(1));
                end else begin
                    o_status = ST_RANGE;
                end
            end
            OP_WRITE, OP_INSERT: begin
                if ((i_op == OP_WRITE) && w_inside) begin
                    o_ctl.cmd = CMD_WRITE;
                end else if (w_idx > w_len) begin
                    if (w_idx1 > CAP) begin
                        o_status = ST_FULL;
                    end else begin
                        o_ctl.cmd = CMD_WRITE;
                        o_len_nxt = LW'(w_idx1);
                    end
                end else if (w_len >= CAP) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.cmd = CMD_SHIFT_UP;
                    o_len_nxt = LW'(w_len + CW'(1));
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

// ===== hw/rtl/insertable_register_array.sv =====
// Insert/delete shift array: a row of CAPACITY signed 32-bit cells and a live length
// (1 after reset, all cells zero). Each transaction carries read, write (overwrite inside
// the length, insert otherwise), insert with upward shift, or remove with downward shift,
// and returns one result with the read word, the length afterward and a status
// (ok, index outside the live entries, array full). Every cell picks hold, neighbor or new
// word in the same cycle, so one transaction is taken per clock and its result appears in the
// output register in the next cycle; a new transaction is taken while that result is
// being read out, and the slave side stalls only while an unread result is held.
module insertable_register_array
    import iar_pkg::*;
#(
    parameter int  CAPACITY = 64,
    localparam int LW       = $clog2(CAPACITY + 1),
    localparam int OUT_W    = ((DATA_W + LW + STAT_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // index[5:0], value[37:6]
    input  logic [OP_W-1:0]     s_axis_tuser,   // operation[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata    // read_value, current_length, status
);

    localparam int PAD_W = OUT_W - DATA_W - LW - STAT_W;

    logic                w_acc;
    t_op                 w_op;
    logic [IDX_W-1:0]    w_idx;
    logic [DATA_W-1:0]   w_value;
    t_cell_ctl           w_ctl;
    logic [LW-1:0]       w_len_nxt;
    t_status             w_status;
    logic                w_rd_ok;
    logic [DATA_W-1:0]   w_q   [CAPACITY];
    logic [DATA_W-1:0]   w_tap [CAPACITY];
    logic [DATA_W-1:0]   w_rd;

    logic [LW-1:0]       r_len;
    logic                r_m_valid;
    logic [DATA_W-1:0]   r_rdata;
    logic [LW-1:0]       r_olen;
    t_status             r_status;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_idx         = s_axis_tdata[IDX_W-1:0];
    assign w_value       = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];

    iar_ctrl #(
        .CAPACITY (CAPACITY),
        .LW       (LW)
    ) u_ctrl (
        .i_op      (w_op),
        .i_idx     (w_idx),
        .i_len     (r_len),
        .o_ctl     (w_ctl),
        .o_len_nxt (w_len_nxt),
        .o_status  (w_status),
        .o_rd_ok   (w_rd_ok)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo
            assign w_left = w_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_q[g+1];
        end
        iar_cell #(
            .CAPACITY (CAPACITY),
            .POS      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_acc),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (w_value),
            .o_q     (w_q[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LW'(1);
            r_m_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_len     <= w_len_nxt;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rdata  <= w_rd_ok ? w_rd : '0;
            r_olen   <= w_len_nxt;
            r_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_status, r_olen, r_rdata};

    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("length beyond capacity");

    a_fail_keeps_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_status != ST_OK)) |=> (r_len == $past(r_len)))
        else $error("failed operation changed length");

    a_err_zero_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_status != ST_OK)) |-> (r_rdata == '0))
        else $error("nonzero read word on error");

    a_remove_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_ctl.cmd == CMD_SHIFT_DOWN)) |=> (r_len == $past(r_len) - LW'(1)))
        else $error("remove did not shrink length");

    a_result_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_olen == r_len) || s_axis_tready)
        else $error("held result length disagrees with state");

endmodule
